// File: sv/rpn_stack_evaluator_unit_macros.svh
// ----------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_UNIT_MACROS_SVH
`define RPN_STACK_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication
`define RPN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn assertion failed");

// next-cycle implication
`define RPN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn assertion failed");

`endif

// File: sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator package
// Transaction types, action, status and ALU codes.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] ACT_LIT = 3'd0;
  localparam logic [2:0] ACT_R0  = 3'd1;
  localparam logic [2:0] ACT_R1  = 3'd2;
  localparam logic [2:0] ACT_ADD = 3'd3;
  localparam logic [2:0] ACT_SUB = 3'd4;
  localparam logic [2:0] ACT_MUL = 3'd5;
  localparam logic [2:0] ACT_DIV = 3'd6;
  localparam logic [2:0] ACT_END = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_DIVZ  = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_R0 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_R1 = 1'b1;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [DATA_W-1:0] literal;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

endpackage

// File: sv/rpn_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Evaluates reverse-Polish tokens on a signed 32-bit stack with error status.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one token per transaction (action, literal); accepted when
//           in_valid is high and in_stall is low. in_stall is high while a
//           token is being worked on.
//   out_* : zero or one result per token (result_value, status); a result
//           is taken when out_valid is high and out_stall is low.
//   cfg_* : writes r0 (index 0) or r1 (index 1); cfg_ready is always high.
// Token flow, set by the stack memory port and the shared ALU:
//   push, dropped token, end after an error: done in idle; end: read top of
//   stack, then emit; add/sub/mul/div: read b, read a, run ALU, write back.
//   Errors emit; a pending result waits on out_stall in the emit state.
// Errors (underflow, divide by zero, overflow) report once, then tokens are
// dropped until the end token. Reset empties the stack, clears the error
// hold and the r0/r1 registers; stack contents are not cleared. While the
// receiver stalls, a pending result holds the block and no token is taken.
// ----------------------------------------------------------------------------
`include "rpn_stack_evaluator_unit_macros.svh"

module rpn_stack_evaluator_unit
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD_B   = 6'b000010,
    S_RD_A   = 6'b000100,
    S_ALU    = 6'b001000,
    S_RD_TOP = 6'b010000,
    S_EMIT   = 6'b100000
  } seq_state_t;

  seq_state_t        st_r, st_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              err_r, err_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  out_item_t         pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [DATA_W-1:0] r0_r, r1_r;

  logic              in_acc;
  logic [LVL_W-1:0]  lvl_m1, lvl_m2;
  logic              is_push;
  logic [DATA_W-1:0] push_val;
  logic [1:0]        tok_op;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  alu_req_t          alu_req;
  logic [DATA_W-1:0] alu_a;
  logic              alu_done;
  logic [DATA_W-1:0] alu_res;

  assign in_acc = in_valid && (st_r == S_IDLE);
  assign lvl_m1 = lvl_r - LVL_W'(1);
  assign lvl_m2 = lvl_r - LVL_W'(2);
  assign is_push = (in_data.action == ACT_LIT) || (in_data.action == ACT_R0) ||
                   (in_data.action == ACT_R1);

  always_comb begin
    case (in_data.action)
      ACT_R0:  push_val = r0_r;
      ACT_R1:  push_val = r1_r;
      default: push_val = in_data.literal;
    endcase
    case (in_data.action)
      ACT_SUB: tok_op = ALU_SUB;
      ACT_MUL: tok_op = ALU_MUL;
      ACT_DIV: tok_op = ALU_DIV;
      default: tok_op = ALU_ADD;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    lvl_nxt       = lvl_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    b_nxt         = b_r;
    pend_nxt      = pend_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = lvl_r[AW-1:0];
    mem_wdata     = push_val;
    mem_re        = 1'b0;
    mem_raddr     = lvl_m1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    alu_a         = mem_rdata;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.action == ACT_END) begin
            lvl_nxt = '0;
            err_nxt = 1'b0;
            if (!err_r) begin
              if (lvl_r == '0) begin
                pend_nxt = '{result_value: '0, status: ST_UNDER};
                st_nxt   = S_EMIT;
              end else begin
                mem_re = 1'b1;
                st_nxt = S_RD_TOP;
              end
            end
          end else if (!err_r) begin
            if (is_push) begin
              if (lvl_r == LVL_W'(STACK_DEPTH)) begin
                pend_nxt = '{result_value: '0, status: ST_OVER};
                err_nxt  = 1'b1;
                st_nxt   = S_EMIT;
              end else begin
                mem_we  = 1'b1;
                lvl_nxt = lvl_r + LVL_W'(1);
              end
            end else if (lvl_r < LVL_W'(2)) begin
              pend_nxt = '{result_value: '0, status: ST_UNDER};
              err_nxt  = 1'b1;
              st_nxt   = S_EMIT;
            end else begin
              mem_re = 1'b1;
              op_nxt = tok_op;
              st_nxt = S_RD_B;
            end
          end
        end
      end
      S_RD_B: begin
        b_nxt = mem_rdata;
        if ((op_r == ALU_DIV) && (mem_rdata == '0)) begin
          pend_nxt = '{result_value: '0, status: ST_DIVZ};
          err_nxt  = 1'b1;
          st_nxt   = S_EMIT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = lvl_m2[AW-1:0];
          st_nxt    = S_RD_A;
        end
      end
      S_RD_A: begin
        alu_req.start = 1'b1;
        st_nxt        = S_ALU;
      end
      S_ALU: begin
        if (alu_done) begin
          mem_we    = 1'b1;
          mem_waddr = lvl_m2[AW-1:0];
          mem_wdata = alu_res;
          lvl_nxt   = lvl_m1;
          st_nxt    = S_IDLE;
        end
      end
      S_RD_TOP: begin
        pend_nxt = '{result_value: mem_rdata, status: ST_OK};
        st_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      lvl_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      r0_r        <= '0;
      r1_r        <= '0;
    end else begin
      st_r        <= st_nxt;
      lvl_r       <= lvl_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_R0:  r0_r <= cfg_data;
          CFG_R1:  r1_r <= cfg_data;
          default: r0_r <= r0_r;
        endcase
      end
    end
    op_r       <= op_nxt;
    b_r        <= b_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpn_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opnd_a (alu_a),
    .opnd_b (b_r),
    .done   (alu_done),
    .res    (alu_res)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  `RPN_ASSERT_IMP(a_lvl_max, 1'b1, lvl_r <= LVL_W'(STACK_DEPTH))
  `RPN_ASSERT_IMP(a_alu_lvl, st_r == S_ALU, lvl_r >= LVL_W'(2))
  `RPN_ASSERT_NXT(a_end_clr, in_acc && (in_data.action == ACT_END), !err_r)

endmodule

// File: sv/rpn_stack_mem.sv
// ----------------------------------------------------------------------------
// RPN stack memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module rpn_stack_mem
  import rpn_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rpn_alu.sv
// ----------------------------------------------------------------------------
// RPN shared arithmetic unit
// One 33-bit adder reused for add, sub, shift-add multiply, restoring divide.
// ----------------------------------------------------------------------------
`include "rpn_stack_evaluator_unit_macros.svh"

module rpn_alu
  import rpn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  alu_req_t          req,
  input  logic [DATA_W-1:0] opnd_a,
  input  logic [DATA_W-1:0] opnd_b,
  output logic              done,
  output logic [DATA_W-1:0] res
);

  typedef enum logic [4:0] {
    A_IDLE   = 5'b00001,
    A_ADDSUB = 5'b00010,
    A_MUL    = 5'b00100,
    A_DIV    = 5'b01000,
    A_FIX    = 5'b10000
  } alu_state_t;

  alu_state_t        st_r, st_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] opb_r, opb_nxt;
  logic [DATA_W-1:0] opq_r, opq_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;

  logic [DATA_W:0]   add_a, add_b;
  logic              add_sub;
  logic [DATA_W+1:0] add_sum;
  logic [DATA_W:0]   shifted;
  logic [DATA_W-1:0] mag_a, mag_b;

  assign add_sum = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                           : ({1'b0, add_a} + {1'b0, add_b});
  assign shifted = {rem_r, opq_r[DATA_W-1]};
  assign mag_a   = opnd_a[DATA_W-1] ? (DATA_W'(0) - opnd_a) : opnd_a;
  assign mag_b   = opnd_b[DATA_W-1] ? (DATA_W'(0) - opnd_b) : opnd_b;

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    opb_nxt  = opb_r;
    opq_nxt  = opq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    add_a    = '0;
    add_b    = '0;
    add_sub  = 1'b0;
    case (st_r)
      A_IDLE: begin
        if (req.start) begin
          op_nxt = req.op;
          cnt_nxt = 5'd31;
          case (req.op)
            ALU_MUL: begin
              acc_nxt = '0;
              opq_nxt = opnd_b;
              opb_nxt = opnd_a;
              st_nxt  = A_MUL;
            end
            ALU_DIV: begin
              opq_nxt = mag_a;
              opb_nxt = mag_b;
              rem_nxt = '0;
              neg_nxt = opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
              st_nxt  = A_DIV;
            end
            default: begin
              opq_nxt = opnd_a;
              opb_nxt = opnd_b;
              st_nxt  = A_ADDSUB;
            end
          endcase
        end
      end
      A_ADDSUB: begin
        add_a    = {1'b0, opq_r};
        add_b    = {1'b0, opb_r};
        add_sub  = (op_r == ALU_SUB);
        acc_nxt  = add_sum[DATA_W-1:0];
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      A_MUL: begin
        add_a   = {1'b0, acc_r};
        add_b   = opq_r[0] ? {1'b0, opb_r} : '0;
        acc_nxt = add_sum[DATA_W-1:0];
        opb_nxt = {opb_r[DATA_W-2:0], 1'b0};
        opq_nxt = {1'b0, opq_r[DATA_W-1:1]};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          done_nxt = 1'b1;
          st_nxt   = A_IDLE;
        end
      end
      A_DIV: begin
        add_a   = shifted;
        add_b   = {1'b0, opb_r};
        add_sub = 1'b1;
        rem_nxt = add_sum[DATA_W+1] ? shifted[DATA_W-1:0] : add_sum[DATA_W-1:0];
        opq_nxt = {opq_r[DATA_W-2:0], ~add_sum[DATA_W+1]};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          st_nxt = A_FIX;
        end
      end
      A_FIX: begin
        add_a    = '0;
        add_b    = {1'b0, opq_r};
        add_sub  = neg_r;
        acc_nxt  = add_sum[DATA_W-1:0];
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    opb_r <= opb_nxt;
    opq_r <= opq_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

  `RPN_ASSERT_IMP(a_start_idle, req.start, st_r == A_IDLE)
  `RPN_ASSERT_NXT(a_done_pulse, done_r, !done_r)
  `RPN_ASSERT_IMP(a_fix_div, st_r == A_FIX, op_r == ALU_DIV)

endmodule
